// ===== rtl/core/abs_pkg.sv =====
`timescale 1ns / 1ps

package abs_pkg;

  // Field widths
  localparam int LIGHT_W = 16;
  localparam int TIME_W  = 32;
  localparam int DUTY_W  = 8;

  // Moving average depth and the widths that follow from it
  localparam int AVG_DEPTH  = 10;
  localparam int AVG_FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int AVG_SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int AVG_SUM_W  = DUTY_W + AVG_FILL_W;

  // Window accumulators
  localparam int WSUM_W   = 24;
  localparam int WCOUNT_W = 16;

  // Shared divider for the average and the window mean
  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Linear map: x / 65535 == (x + (x >> 16) + 1) >> 16 for any 24-bit product
  localparam int MAP_PROD_W = LIGHT_W + DUTY_W;
  localparam int MAP_SHIFT  = 16;

  // Ramp arithmetic: elapsed time is below RAMP_MS whenever it is scaled
  localparam int RAMP_EL_W   = 9;
  localparam int RAMP_PROD_W = DUTY_W + RAMP_EL_W;

  // Ramp division by 500 as a reciprocal multiply, exact for 17-bit products
  localparam int                    RAMP_RECIP_W = 18;
  localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP = 18'd134218;
  localparam int                    RAMP_SHIFT   = 26;
  localparam int                    RAMP_SCALE_W = RAMP_PROD_W + RAMP_RECIP_W;

  // Timing and scale constants
  localparam logic [TIME_W-1:0]  WINDOW_MS  = 32'd500;
  localparam logic [TIME_W-1:0]  RAMP_MS    = 32'd500;
  localparam logic [DIV_D_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [DUTY_W-1:0]  DUTY_RESET = 8'd50;
  localparam logic [DUTY_W-1:0]  MIN_RESET  = 8'd10;
  localparam logic [DUTY_W-1:0]  MAX_RESET  = 8'd255;

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS = 4'd1;

  // Divider operand selection
  typedef enum logic {
    DIV_AVG,
    DIV_WIN
  } div_sel_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_CALC,
    ST_MAP_APPLY,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_WIN_CHECK,
    ST_WIN_WAIT,
    ST_RAMP_CHECK,
    ST_RAMP_APPLY,
    ST_DONE
  } abs_state_e;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     map_calc;
    logic     div_start;
    div_sel_e div_sel;
    logic     map_commit;
    logic     avg_commit;
    logic     win_commit;
    logic     ramp_calc;
    logic     ramp_commit;
    logic     ramp_hold;
    logic     out_load;
  } abs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic win_close;
    logic ramp_active;
  } abs_status_t;

endpackage

// ===== rtl/core/ambient_brightness_smoother_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    light_sample_i, now_ms_i
// out      output     out_valid_o / out_ready_i  pwm_duty_o, new_target_o
// cfg      input      cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// The average and the window mean share one divider that retires one quotient
// bit a cycle; the map and ramp scalings are reciprocal multiplies.
// Asynchronous active-low reset; state comes up as after power-on, no clearing pass.
// A new transaction is taken while the previous result still waits in the output
// register; the sequencer only stalls at its last step if that register is full.

module ambient_brightness_smoother_top import abs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [LIGHT_W-1:0]   light_sample_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DUTY_W-1:0]    pwm_duty_o,
  output logic                 new_target_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUTY_W-1:0]    cfg_wdata_i
);

  abs_cmd_t    cmd;
  abs_status_t status;

  // Sequencer
  abs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  abs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .light_sample_i (light_sample_i),
    .now_ms_i       (now_ms_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pwm_duty_o     (pwm_duty_o),
    .new_target_o   (new_target_o)
  );

endmodule

// ===== rtl/core/abs_divider.sv =====
`timescale 1ns / 1ps

module abs_divider import abs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quotient_o
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_N_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     trial_sub;
  logic                 fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial     = {rem_q, quo_q[DIV_N_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    done_d = busy_q && (cnt_q == DIV_LAST);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_d = {quo_q[DIV_N_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // A new division is only issued once the previous one has finished
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/abs_datapath.sv =====
`timescale 1ns / 1ps

module abs_datapath import abs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  abs_cmd_t             cmd_i,
  output abs_status_t          status_o,
  input  logic [LIGHT_W-1:0]   light_sample_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUTY_W-1:0]    cfg_wdata_i,
  output logic [DUTY_W-1:0]    pwm_duty_o,
  output logic                 new_target_o
);

  // Configuration
  logic [DUTY_W-1:0] min_q, max_q;

  // Captured transaction
  logic [LIGHT_W-1:0] light_q;
  logic [TIME_W-1:0]  now_q;

  // Moving average
  logic [DUTY_W-1:0]     hist_q [AVG_DEPTH];
  logic [AVG_SUM_W-1:0]  avg_sum_q, avg_sum_d;
  logic [AVG_FILL_W-1:0] avg_fill_q, avg_fill_d;
  logic [AVG_SLOT_W-1:0] avg_slot_q, avg_slot_d;

  // Window and ramp
  logic [WSUM_W-1:0]   wsum_q, wsum_d;
  logic [WCOUNT_W-1:0] wcount_q, wcount_d;
  logic [TIME_W-1:0]   win_start_q;
  logic [TIME_W-1:0]   ramp_start_q;
  logic [DUTY_W-1:0]   ramp_from_q, ramp_to_q, duty_q;
  logic                latched_q;

  // Scaled intermediates
  logic [DUTY_W-1:0]      map_quo_q;
  logic [RAMP_PROD_W-1:0] ramp_prod_q;

  // Result register
  logic [DUTY_W-1:0] out_duty_q;
  logic              out_new_q;

  // Divider
  logic               div_done;
  logic [DIV_N_W-1:0] quo;
  logic [DIV_N_W-1:0] dividend;
  logic [DIV_D_W-1:0] divisor;

  // Combinational helpers
  logic                   map_up;
  logic [DUTY_W-1:0]      map_span;
  logic [MAP_PROD_W-1:0]  map_prod;
  logic [DUTY_W-1:0]      map_quo;
  logic [DUTY_W-1:0]      mapped;
  logic [DUTY_W-1:0]      quo8;
  logic [WSUM_W:0]        wsum_ext;
  logic [DUTY_W-1:0]      win_mean;
  logic [TIME_W-1:0]      win_elapsed;
  logic [TIME_W-1:0]      ramp_elapsed;
  logic                   ramp_up;
  logic [DUTY_W-1:0]      ramp_diff;
  logic [RAMP_PROD_W-1:0] ramp_prod;
  logic [DUTY_W-1:0]      ramp_quo;

  assign quo8 = quo[DUTY_W-1:0];

  // Linear map: magnitude of raw * (max - min), quotient applied from min toward max
  assign map_up   = (max_q >= min_q);
  assign map_span = map_up ? (max_q - min_q) : (min_q - max_q);
  assign map_prod = MAP_PROD_W'(light_q) * MAP_PROD_W'(map_span);
  assign map_quo  = DUTY_W'((map_prod + (map_prod >> MAP_SHIFT) + 1'b1) >> MAP_SHIFT);
  assign mapped   = map_up ? (min_q + map_quo_q) : (min_q - map_quo_q);

  // Window test and mean clamp
  assign win_elapsed = now_q - win_start_q;
  assign win_mean    = (|quo[DIV_N_W-1:DUTY_W]) ? '1 : quo8;
  assign wsum_ext    = {1'b0, wsum_q} + (WSUM_W + 1)'(quo8);

  // Ramp scaling: product registered, then divided by 500 via the reciprocal
  assign ramp_elapsed = now_q - ramp_start_q;
  assign ramp_up      = (ramp_to_q >= ramp_from_q);
  assign ramp_diff    = ramp_up ? (ramp_to_q - ramp_from_q) : (ramp_from_q - ramp_to_q);
  assign ramp_prod    = RAMP_PROD_W'(ramp_diff) * RAMP_PROD_W'(ramp_elapsed[RAMP_EL_W-1:0]);
  assign ramp_quo     = DUTY_W'((RAMP_SCALE_W'(ramp_prod_q) * RAMP_SCALE_W'(RAMP_RECIP))
                                >> RAMP_SHIFT);

  assign status_o.div_done    = div_done;
  assign status_o.win_close   = (win_elapsed >= WINDOW_MS);
  assign status_o.ramp_active = (ramp_elapsed < RAMP_MS);

  // Divider operand selection
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_AVG: begin
        dividend = DIV_N_W'(avg_sum_q) + DIV_N_W'(avg_fill_q >> 1);
        divisor  = DIV_D_W'(avg_fill_q);
      end
      DIV_WIN: begin
        dividend = wsum_q;
        divisor  = wcount_q;
      end
    endcase
  end

  abs_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Moving average update once the mapped sample is known
  always_comb begin
    avg_sum_d  = avg_sum_q;
    avg_fill_d = avg_fill_q;
    avg_slot_d = avg_slot_q;
    if (cmd_i.map_commit) begin
      if (avg_fill_q < AVG_FILL_W'(AVG_DEPTH)) begin
        avg_fill_d = avg_fill_q + 1'b1;
        avg_sum_d  = avg_sum_q + AVG_SUM_W'(mapped);
      end else begin
        avg_sum_d = avg_sum_q - AVG_SUM_W'(hist_q[avg_slot_q]) + AVG_SUM_W'(mapped);
      end
      avg_slot_d = (avg_slot_q == AVG_SLOT_W'(AVG_DEPTH - 1)) ? '0 : avg_slot_q + 1'b1;
    end
  end

  // Window accumulation, saturating
  always_comb begin
    wsum_d   = wsum_q;
    wcount_d = wcount_q;
    if (cmd_i.avg_commit) begin
      wsum_d   = wsum_ext[WSUM_W] ? '1 : wsum_ext[WSUM_W-1:0];
      wcount_d = (wcount_q != '1) ? wcount_q + 1'b1 : wcount_q;
    end else if (cmd_i.win_commit) begin
      wsum_d   = '0;
      wcount_d = '0;
    end
  end

  // State with defined reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= MIN_RESET;
      max_q        <= MAX_RESET;
      avg_sum_q    <= '0;
      avg_fill_q   <= '0;
      avg_slot_q   <= '0;
      wsum_q       <= '0;
      wcount_q     <= '0;
      win_start_q  <= '0;
      ramp_start_q <= '0;
      ramp_from_q  <= DUTY_RESET;
      ramp_to_q    <= DUTY_RESET;
      duty_q       <= DUTY_RESET;
      latched_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_MIN_BRIGHTNESS)) begin
        min_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_MAX_BRIGHTNESS)) begin
        max_q <= cfg_wdata_i;
      end
      avg_sum_q  <= avg_sum_d;
      avg_fill_q <= avg_fill_d;
      avg_slot_q <= avg_slot_d;
      wsum_q     <= wsum_d;
      wcount_q   <= wcount_d;
      if (cmd_i.load_in) begin
        latched_q <= 1'b0;
      end
      if (cmd_i.win_commit) begin
        win_start_q  <= now_q;
        ramp_start_q <= now_q;
        ramp_from_q  <= duty_q;
        ramp_to_q    <= win_mean;
        latched_q    <= 1'b1;
      end
      if (cmd_i.ramp_commit) begin
        duty_q <= ramp_up ? (ramp_from_q + ramp_quo) : (ramp_from_q - ramp_quo);
      end else if (cmd_i.ramp_hold) begin
        duty_q <= ramp_to_q;
      end
    end
  end

  // Payload: captured transaction, intermediates, history and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      light_q <= light_sample_i;
      now_q   <= now_ms_i;
    end
    if (cmd_i.map_calc) begin
      map_quo_q <= map_quo;
    end
    if (cmd_i.ramp_calc) begin
      ramp_prod_q <= ramp_prod;
    end
    if (cmd_i.map_commit) begin
      hist_q[avg_slot_q] <= mapped;
    end
    if (cmd_i.out_load) begin
      out_duty_q <= duty_q;
      out_new_q  <= latched_q;
    end
  end

  assign pwm_duty_o   = out_duty_q;
  assign new_target_o = out_new_q;

  // The mapped quotient never exceeds the span
  a_map_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.map_commit |-> (map_quo_q <= map_span))
    else $error("mapped quotient out of range");

  // A ramp step lands between its start and its target
  a_ramp_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ramp_commit |=> ((duty_q >= ramp_from_q) && (duty_q <= ramp_to_q)) ||
                          ((duty_q <= ramp_from_q) && (duty_q >= ramp_to_q)))
    else $error("ramp duty outside its end points");

endmodule

// ===== rtl/core/abs_ctrl.sv =====
`timescale 1ns / 1ps

module abs_ctrl import abs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  abs_status_t status_i,
  output abs_cmd_t    cmd_o
);

  abs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_MAP_CALC;
      ST_MAP_CALC:   state_d = ST_MAP_APPLY;
      ST_MAP_APPLY:  state_d = ST_AVG_START;
      ST_AVG_START:  state_d = ST_AVG_WAIT;
      ST_AVG_WAIT:   if (status_i.div_done) state_d = ST_WIN_CHECK;
      ST_WIN_CHECK:  state_d = status_i.win_close ? ST_WIN_WAIT : ST_RAMP_CHECK;
      ST_WIN_WAIT:   if (status_i.div_done) state_d = ST_RAMP_CHECK;
      ST_RAMP_CHECK: state_d = status_i.ramp_active ? ST_RAMP_APPLY : ST_DONE;
      ST_RAMP_APPLY: state_d = ST_DONE;
      ST_DONE:       if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.div_sel = DIV_AVG;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_MAP_CALC: begin
        cmd_o.map_calc = 1'b1;
      end
      ST_MAP_APPLY: begin
        cmd_o.map_commit = 1'b1;
      end
      ST_AVG_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_AVG;
      end
      ST_AVG_WAIT: begin
        cmd_o.avg_commit = status_i.div_done;
      end
      ST_WIN_CHECK: begin
        cmd_o.div_start = status_i.win_close;
        cmd_o.div_sel   = DIV_WIN;
      end
      ST_WIN_WAIT: begin
        cmd_o.win_commit = status_i.div_done;
      end
      ST_RAMP_CHECK: begin
        cmd_o.ramp_calc = status_i.ramp_active;
        cmd_o.ramp_hold = !status_i.ramp_active;
      end
      ST_RAMP_APPLY: begin
        cmd_o.ramp_commit = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The result register is never overwritten while its transaction is pending
  a_out_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import abs_pkg::*;

  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_SAMPLES = 142;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned MAX_PRINTED   = 40;

  // One expected duty update
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              latched;
  } duty_result_t;

  // Predicts the smoothed duty and compares it with what the block returns
  class duty_scoreboard;
    logic [DUTY_W-1:0]    lo_duty;
    logic [DUTY_W-1:0]    hi_duty;
    logic [DUTY_W-1:0]    history [AVG_DEPTH];
    logic [AVG_SUM_W-1:0] hist_total;
    int unsigned          hist_fill;
    int unsigned          hist_slot;
    logic [WSUM_W-1:0]    win_sum;
    logic [WCOUNT_W-1:0]  win_count;
    logic [TIME_W-1:0]    win_start;
    logic [TIME_W-1:0]    ramp_t0;
    logic [DUTY_W-1:0]    ramp_from;
    logic [DUTY_W-1:0]    ramp_to;
    logic [DUTY_W-1:0]    duty_now;
    duty_result_t         pending_duty [$];
    int unsigned          errors;
    int unsigned          samples;
    int unsigned          targets;

    function new();
      lo_duty    = MIN_RESET;
      hi_duty    = MAX_RESET;
      hist_total = '0;
      hist_fill  = 0;
      hist_slot  = 0;
      win_sum    = '0;
      win_count  = '0;
      win_start  = '0;
      ramp_t0    = '0;
      ramp_from  = DUTY_RESET;
      ramp_to    = DUTY_RESET;
      duty_now   = DUTY_RESET;
      errors     = 0;
      samples    = 0;
      targets    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
      case (idx)
        REG_MIN_BRIGHTNESS: lo_duty = data;
        REG_MAX_BRIGHTNESS: hi_duty = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_duty.size();
    endfunction

    // Accepted sample: map, smooth, accumulate the window and advance the ramp
    function void note_sample(logic [LIGHT_W-1:0] light, logic [TIME_W-1:0] now);
      longint            scaled;
      logic [DUTY_W-1:0] mapped;
      int unsigned       smooth;
      int unsigned       wide_sum;
      int unsigned       mean;
      int unsigned       delta;
      logic [TIME_W-1:0] since;
      logic              closed;
      duty_result_t      res;

      // linear map, signed division truncates toward zero
      scaled = (longint'(light) * (longint'(hi_duty) - longint'(lo_duty)))
               / longint'(FULL_SCALE) + longint'(lo_duty);
      mapped = scaled[DUTY_W-1:0];

      // moving average over the entries present
      if (hist_fill < AVG_DEPTH) begin
        hist_fill++;
        hist_total = hist_total + mapped;
      end else begin
        hist_total = hist_total - history[hist_slot] + mapped;
      end
      history[hist_slot] = mapped;
      hist_slot = (hist_slot + 1) % AVG_DEPTH;
      smooth = (hist_total + hist_fill / 2) / hist_fill;

      // window accumulators saturate independently
      wide_sum = win_sum + smooth;
      win_sum  = (wide_sum > 32'h00FF_FFFF) ? '1 : wide_sum[WSUM_W-1:0];
      if (win_count != '1) win_count++;

      closed = 1'b0;
      since  = now - win_start;
      if (since >= WINDOW_MS) begin
        mean = win_sum / win_count;
        if (mean > 255) mean = 255;
        win_start = now;
        win_sum   = '0;
        win_count = '0;
        ramp_from = duty_now;
        ramp_to   = mean[DUTY_W-1:0];
        ramp_t0   = now;
        closed    = 1'b1;
        targets++;
      end

      // linear ramp towards the latched target
      since = now - ramp_t0;
      if (since < RAMP_MS) begin
        if (ramp_to >= ramp_from) begin
          delta    = ((ramp_to - ramp_from) * since) / RAMP_MS;
          duty_now = ramp_from + delta[DUTY_W-1:0];
        end else begin
          delta    = ((ramp_from - ramp_to) * since) / RAMP_MS;
          duty_now = ramp_from - delta[DUTY_W-1:0];
        end
      end else begin
        duty_now = ramp_to;
      end

      res.duty    = duty_now;
      res.latched = closed;
      pending_duty.push_back(res);
      samples++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [DUTY_W-1:0] duty, logic latched);
      duty_result_t want;
      if (pending_duty.size() == 0) begin
        report($sformatf("result with nothing expected: duty %0d new_target %0b",
                         duty, latched));
      end else begin
        want = pending_duty.pop_front();
        if (duty !== want.duty)
          report($sformatf("pwm_duty %0d, expected %0d", duty, want.duty));
        if (latched !== want.latched)
          report($sformatf("new_target %0b, expected %0b", latched, want.latched));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [LIGHT_W-1:0]   light_sample_i = '0;
  logic [TIME_W-1:0]    now_ms_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [DUTY_W-1:0]    pwm_duty_o;
  logic                 new_target_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [DUTY_W-1:0]    cfg_wdata_i    = '0;

  duty_scoreboard    sb = new();
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       settings_used  = 1;
  logic [TIME_W-1:0] stamp_ms       = '0;

  ambient_brightness_smoother_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .light_sample_i (light_sample_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pwm_duty_o     (pwm_duty_o),
    .new_target_o   (new_target_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Input transaction; optional idle gap first, valid held until taken
  task automatic send_sample(logic [LIGHT_W-1:0] light, logic [TIME_W-1:0] now);
    if (chance(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    light_sample_i <= light;
    now_ms_i       <= now;
    stamp_ms        = now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(light, now);
  endtask

  // Hold the sender until every outstanding result is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Back-to-back register writes, optionally followed by one to a spare index
  task automatic apply_limits(logic [DUTY_W-1:0] lo, logic [DUTY_W-1:0] hi, bit poke_spare);
    logic [CFG_IDX_W-1:0] spare;
    logic [DUTY_W-1:0]    junk;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MIN_BRIGHTNESS;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    sb.write_reg(REG_MIN_BRIGHTNESS, lo);
    cfg_idx_i   <= REG_MAX_BRIGHTNESS;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    sb.write_reg(REG_MAX_BRIGHTNESS, hi);
    if (poke_spare) begin
      spare = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_MAX_BRIGHTNESS + 1));
      junk  = DUTY_W'($urandom_range(255, 0));
      cfg_idx_i   <= spare;
      cfg_wdata_i <= junk;
      @(posedge clk_i);
      sb.write_reg(spare, junk);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Result side: random back-pressure, check on each accepted transaction
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result(pwm_duty_o, new_target_o);
      out_ready_i <= !chance(recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted transaction
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("[ambient_brightness_smoother_top] ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned       pick;
    logic [DUTY_W-1:0] lo;
    logic [DUTY_W-1:0] hi;
    logic [LIGHT_W-1:0] light;
    logic [TIME_W-1:0] now;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset limits, window edges at 499/500, history wrap, time wrap
    send_sample(16'd0,     32'd0);
    send_sample(16'd65535, 32'd120);
    send_sample(16'd32768, 32'd499);
    send_sample(16'd65535, 32'd500);
    send_sample(16'd0,     32'd501);
    send_sample(16'd1,     32'd750);
    send_sample(16'd65534, 32'd999);
    send_sample(16'd65535, 32'd1000);
    send_sample(16'd0,     32'd1200);
    send_sample(16'd0,     32'd1499);
    send_sample(16'd40000, 32'd1500);
    send_sample(16'd65535, 32'd1700);
    send_sample(16'd20000, 32'hFFFF_FE00);
    send_sample(16'd20000, 32'hFFFF_FF00);
    send_sample(16'd65535, 32'hFFFF_FFFF);
    send_sample(16'd0,     32'h0000_0100);

    // directed: inverted limits map downward
    wait_for_results();
    apply_limits(8'd255, 8'd0, 1'b1);
    send_sample(16'd0,     32'h0000_0300);
    send_sample(16'd65535, 32'h0000_0500);
    send_sample(16'd1,     32'h0000_0700);
    send_sample(16'd32767, 32'h0000_0900);

    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      case (p)
        0: begin lo = 8'd0;   hi = 8'd255; end
        1: begin lo = 8'd255; hi = 8'd0;   end
        2: begin lo = 8'd0;   hi = 8'd0;   end
        3: begin lo = 8'd255; hi = 8'd255; end
        4: begin lo = 8'd200; hi = 8'd37;  end
        default: begin
          lo = DUTY_W'($urandom_range(255, 0));
          hi = DUTY_W'($urandom_range(255, 0));
        end
      endcase
      apply_limits(lo, hi, p[0]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // run close to the 32-bit wrap in one phase
      if (p == 4) stamp_ms = 32'hFFFF_F000;

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (p == 5 && n == PHASE_SAMPLES / 2) wait_for_results();

        // mostly steady time progress, some window edges, some jumps backward
        pick = $urandom_range(99, 0);
        if (pick < 78)
          now = stamp_ms + $urandom_range(120, 0);
        else if (pick < 88)
          now = stamp_ms + $urandom_range(700, 120);
        else if (pick < 92)
          now = sb.win_start + WINDOW_MS - 1 + $urandom_range(2, 0);
        else if (pick < 96)
          now = $urandom();
        else
          now = stamp_ms - $urandom_range(600, 1);

        pick = $urandom_range(99, 0);
        if (pick < 10)
          light = '0;
        else if (pick < 20)
          light = '1;
        else
          light = LIGHT_W'($urandom_range(65535, 0));

        send_sample(light, now);
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d light samples under %0d brightness limit settings,",
             sb.samples, settings_used);
    $display("with %0d ramp targets latched and idle/stall patterns on both sides.",
             sb.targets);
    if (sb.errors == 0) begin
      $display("[ambient_brightness_smoother_top] OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[ambient_brightness_smoother_top] ERROR");
    end
    $finish;
  end

endmodule
